### src/fgs_pkg.sv
// Package for the fuzzy gain scheduler: fixed-point constants, payload structs,
// configuration register codes and the queue item passed from front to back.
// No dependencies.
package fgs_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int NUM_SETS    = 7;
  localparam int HALF        = (NUM_SETS - 1) / 2;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int CLAMP_LIM   = HALF * ONE;
  localparam int SET_IDX_W   = $clog2(NUM_SETS);
  localparam int POS_W       = FRAC_BITS + SET_IDX_W;
  localparam int WEIGHT_W    = FRAC_BITS + 1;
  localparam int RULE_W      = 3;
  localparam int RULE_BITS   = NUM_SETS * NUM_SETS * RULE_W;
  localparam int QUEUE_DEPTH = 2;

  localparam int IN_W        = 16;
  localparam int VAL_W       = 15;
  localparam int GAIN_W      = 12;
  localparam int SCALE_W     = 8;
  localparam int OFFSET_W    = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 63;
  localparam int ROW_LAST_W  = 21;

  localparam logic [SCALE_W-1:0]         SCALE_RST  = 8'd100;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 11'sd300;

  typedef struct packed {
    logic signed [IN_W-1:0] error_in;
    logic signed [IN_W-1:0] error_rate_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  fuzzy_value;
    logic signed [GAIN_W-1:0] gain;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULE_LOW  = 3'd0,
    CFG_RULE_MID  = 3'd1,
    CFG_RULE_LAST = 3'd2,
    CFG_SCALE     = 3'd3,
    CFG_OFFSET    = 3'd4
  } cfg_idx_t;

  typedef logic [NUM_SETS-1:0][NUM_SETS-1:0][RULE_W-1:0] rule_tbl_t;

  typedef struct packed {
    logic [1:0][WEIGHT_W-1:0] w_err;
    logic [1:0][WEIGHT_W-1:0] w_rate;
    logic [3:0][RULE_W-1:0]   rule;
  } q_item_t;

  typedef struct packed {
    logic [SCALE_W-1:0]         scale;
    logic signed [OFFSET_W-1:0] offset;
  } gain_cfg_t;

  typedef struct packed {
    logic [SET_IDX_W-1:0] lo;
    logic [SET_IDX_W-1:0] hi;
    logic [WEIGHT_W-1:0]  w_lo;
    logic [WEIGHT_W-1:0]  w_hi;
  } fz_t;

endpackage

### src/fgs_front.sv
// Front end: takes an input transfer, clamps and fuzzifies both inputs and
// picks the four active rule entries. Depends on fgs_pkg.
module fgs_front import fgs_pkg::*; (
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  rule_tbl_t rule_tbl,
  output logic      push,
  output q_item_t   push_item
);

  function automatic fz_t fuzzify(input logic signed [IN_W-1:0] x);
    logic signed [IN_W:0]  xc;
    logic signed [IN_W:0]  s;
    logic [FRAC_BITS-1:0]  frac;
    fz_t                   f;
    xc = {x[IN_W-1], x};
    if (xc > (IN_W+1)'(CLAMP_LIM)) xc = (IN_W+1)'(CLAMP_LIM);
    if (xc < -(IN_W+1)'(CLAMP_LIM)) xc = -(IN_W+1)'(CLAMP_LIM);
    s      = xc + (IN_W+1)'(CLAMP_LIM);
    frac   = s[FRAC_BITS-1:0];
    f.lo   = s[POS_W-1:FRAC_BITS];
    f.hi   = (f.lo == SET_IDX_W'(NUM_SETS - 1)) ? f.lo : f.lo + SET_IDX_W'(1);
    f.w_hi = {1'b0, frac};
    f.w_lo = WEIGHT_W'(ONE) - {1'b0, frac};
    return f;
  endfunction

  fz_t fz_err;
  fz_t fz_rate;

  assign push    = start && !busy;
  assign fz_err  = fuzzify(in_item.error_in);
  assign fz_rate = fuzzify(in_item.error_rate_in);

  always_comb begin
    push_item.w_err[0]  = fz_err.w_lo;
    push_item.w_err[1]  = fz_err.w_hi;
    push_item.w_rate[0] = fz_rate.w_lo;
    push_item.w_rate[1] = fz_rate.w_hi;
    push_item.rule[0]   = rule_tbl[fz_err.lo][fz_rate.lo];
    push_item.rule[1]   = rule_tbl[fz_err.lo][fz_rate.hi];
    push_item.rule[2]   = rule_tbl[fz_err.hi][fz_rate.lo];
    push_item.rule[3]   = rule_tbl[fz_err.hi][fz_rate.hi];
  end

endmodule

### src/fgs_queue.sv
// Short FIFO between front and back ends, registered storage.
// Depends on fgs_pkg.
module fgs_queue import fgs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output q_item_t head_item,
  output logic    not_empty,
  output logic    full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign head_item = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/fgs_back.sv
// Back end: weights the rule entries, rounds and saturates the value, then
// scales and offsets it into the gain. Five register stages. Depends on fgs_pkg.
module fgs_back import fgs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_item_t   q_item,
  input  gain_cfg_t gain_cfg,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_result
);

  localparam int PROD_W  = 2 * WEIGHT_W;
  localparam int TERM_W  = PROD_W + 1 + RULE_W;
  localparam int SUM_W   = 2 * FRAC_BITS + 4;
  localparam int GPROD_W = SCALE_W + 1 + VAL_W;
  localparam int GSUM_W  = GAIN_W + 1;

  localparam logic signed [SUM_W-1:0]  VAL_MAX_S  = SUM_W'((1 << (VAL_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  VAL_MIN_S  = -SUM_W'(1 << (VAL_W - 1));
  localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(ONE >> 1);
  localparam logic signed [GSUM_W-1:0] GAIN_MAX_S = GSUM_W'((1 << (GAIN_W - 1)) - 1);
  localparam logic signed [GSUM_W-1:0] GAIN_MIN_S = -GSUM_W'(1 << (GAIN_W - 1));

  logic                         v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic [3:0][PROD_W-1:0]       prod_r, prod_nxt;
  logic [3:0][RULE_W-1:0]       rule1_r;
  logic signed [SUM_W-1:0]      sum_r, sum_nxt;
  logic signed [VAL_W-1:0]      val3_r, val3_nxt;
  logic signed [VAL_W-1:0]      val4_r;
  logic signed [GPROD_W-1:0]    gprod_r, gprod_nxt;
  out_item_t                    out_result_r, out_result_nxt;

  assign q_pop      = q_valid;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = q_item.w_err[i / 2] * q_item.w_rate[i % 2];
    end
  end

  always_comb begin
    logic signed [TERM_W-1:0] term;
    sum_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      term    = $signed({1'b0, prod_r[i]}) * $signed(rule1_r[i]);
      sum_nxt = sum_nxt + $signed(term[SUM_W-1:0]);
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] biased;
    logic signed [SUM_W-1:0] scaled;
    biased = sum_r + ROUND_HALF;
    scaled = biased >>> FRAC_BITS;
    if (scaled > VAL_MAX_S) begin
      val3_nxt = VAL_MAX_S[VAL_W-1:0];
    end else if (scaled < VAL_MIN_S) begin
      val3_nxt = VAL_MIN_S[VAL_W-1:0];
    end else begin
      val3_nxt = scaled[VAL_W-1:0];
    end
  end

  assign gprod_nxt = $signed({1'b0, gain_cfg.scale}) * val3_r;

  always_comb begin
    logic signed [GPROD_W-1:0] shifted;
    logic signed [GSUM_W-1:0]  gsum;
    shifted = gprod_r >>> FRAC_BITS;
    gsum    = $signed(shifted[GSUM_W-1:0])
            + $signed({{(GSUM_W-OFFSET_W){gain_cfg.offset[OFFSET_W-1]}}, gain_cfg.offset});
    out_result_nxt.fuzzy_value = val4_r;
    if (gsum > GAIN_MAX_S) begin
      out_result_nxt.gain = GAIN_MAX_S[GAIN_W-1:0];
    end else if (gsum < GAIN_MIN_S) begin
      out_result_nxt.gain = GAIN_MIN_S[GAIN_W-1:0];
    end else begin
      out_result_nxt.gain = gsum[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    rule1_r      <= q_item.rule;
    sum_r        <= sum_nxt;
    val3_r       <= val3_nxt;
    val4_r       <= val3_r;
    gprod_r      <= gprod_nxt;
    out_result_r <= out_result_nxt;
  end

endmodule

### src/fuzzy_gain_scheduler.sv
// Top level of the fuzzy gain scheduler: configuration registers, front end,
// queue and back end. Depends on fgs_pkg, fgs_front, fgs_queue and fgs_back.
//
// One error pair may be started in every clock cycle; busy is high only in
// reset or if the front-to-back queue fills, which does not happen since the
// back end drains it every cycle. Each transfer yields one result, strobed by
// out_valid for a single cycle, after one queue slot plus five back-end
// register stages (weight products, weighted sum, rounding, scale multiply,
// offset and saturation). The receiver cannot stall and must take each result
// in its cycle. Rule table, scale and offset are to be written through the cfg
// port only while no item is in flight; the block itself does not enforce it.
module fuzzy_gain_scheduler import fgs_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_item,
  output logic                   out_valid,
  output out_item_t              out_result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CFG_DATA_W-1:0]       rule_low_r, rule_low_nxt;
  logic [CFG_DATA_W-1:0]       rule_mid_r, rule_mid_nxt;
  logic [ROW_LAST_W-1:0]       rule_last_r, rule_last_nxt;
  gain_cfg_t                   gain_cfg_r, gain_cfg_nxt;
  cfg_idx_t                    cfg_sel;
  rule_tbl_t                   rule_tbl;
  logic                        q_full, q_not_empty, q_pop, push;
  q_item_t                     push_item, head_item;

  assign cfg_ready = rst_n;
  assign busy      = q_full || !rst_n;
  assign cfg_sel   = cfg_idx_t'(cfg_index);
  assign rule_tbl  = rule_tbl_t'({rule_last_r, rule_mid_r, rule_low_r});

  always_comb begin
    rule_low_nxt  = rule_low_r;
    rule_mid_nxt  = rule_mid_r;
    rule_last_nxt = rule_last_r;
    gain_cfg_nxt  = gain_cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_sel)
        CFG_RULE_LOW:  rule_low_nxt = cfg_data;
        CFG_RULE_MID:  rule_mid_nxt = cfg_data;
        CFG_RULE_LAST: rule_last_nxt = cfg_data[ROW_LAST_W-1:0];
        CFG_SCALE:     gain_cfg_nxt.scale = cfg_data[SCALE_W-1:0];
        CFG_OFFSET:    gain_cfg_nxt.offset = $signed(cfg_data[OFFSET_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_low_r        <= '0;
      rule_mid_r        <= '0;
      rule_last_r       <= '0;
      gain_cfg_r.scale  <= SCALE_RST;
      gain_cfg_r.offset <= OFFSET_RST;
    end else begin
      rule_low_r  <= rule_low_nxt;
      rule_mid_r  <= rule_mid_nxt;
      rule_last_r <= rule_last_nxt;
      gain_cfg_r  <= gain_cfg_nxt;
    end
  end

  fgs_front u_front (
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .rule_tbl  (rule_tbl),
    .push      (push),
    .push_item (push_item)
  );

  fgs_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  fgs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_item     (head_item),
    .gain_cfg   (gain_cfg_r),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("accepted item produced no result six cycles later");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result strobe without a matching transfer");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.fuzzy_value <= 15'sd12288))
    else $error("fuzzy value above the largest rule weight");
`endif

endmodule
